[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication in the same cycle, off during reset.
`define PNB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Implication into the next cycle, off during reset.
`define PNB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
// Implication into the next cycle, live during reset.
`define PNB_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication across reset");
`endif

[rtl/core/pnb_pkg.sv]
// Shared constants for the polygon normals and bounding box block.
package pnb_pkg;
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF   = 16;
   localparam int Q_BITS           = 16;
   localparam int IDX_BITS         = 6;
   localparam int NSUM_BITS        = 17;
   localparam int DIV_STEPS        = 31;
   localparam int ROOT_STEPS       = 16;
   localparam int ROOT_W           = 32;
   localparam logic [ROOT_W-1:0] ROOT_TOP = 32'h4000_0000;
endpackage

[rtl/core/pnb_ram.sv]
// Synchronous memory, one write port and two registered read ports.
module pnb_ram #(
   parameter int W     = 32,
   parameter int DEPTH = 64,
   parameter int IW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic [IW-1:0] rd_addr_a,
   input  logic [IW-1:0] rd_addr_b,
   output logic [W-1:0]  rd_data_a,
   output logic [W-1:0]  rd_data_b
);
   logic [W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

[rtl/core/pnb_norm.sv]
// Vector normalizer: restoring divide then integer square root, per component.
module pnb_norm import pnb_pkg::*; #(
   parameter int AW = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [AW-1:0]     a_in,
   input  logic signed [AW-1:0]     b_in,
   output logic                     done,
   output logic signed [Q_BITS-1:0] nx,
   output logic signed [Q_BITS-1:0] ny
);
   localparam int SQW = 2*AW + 1;
   localparam int RW  = SQW + 1;
   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_SQ   = 3'd1;
   localparam logic [2:0] U_SUM  = 3'd2;
   localparam logic [2:0] U_DIV  = 3'd3;
   localparam logic [2:0] U_ROOT = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           ua_ff, ua_in, ub_ff, ub_in;
   logic                    a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic [2*AW-1:0]         ua2_ff, ua2_in, ub2_ff, ub2_in;
   logic [SQW-1:0]          sq_ff, sq_in;
   logic [RW-1:0]           rem_ff, rem_in;
   logic [DIV_STEPS-1:0]    quo_ff, quo_in;
   logic [ROOT_W-1:0]       rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic                    phase_ff, phase_in;
   logic                    done_ff, done_in;
   logic signed [Q_BITS-1:0] nx_ff, nx_in, ny_ff, ny_in;

   logic                    ge;
   logic [RW-1:0]           diff;
   logic [ROOT_W-1:0]       trial;
   logic [ROOT_W-1:0]       root_rnd;
   logic [Q_BITS-1:0]       mag;
   logic signed [Q_BITS-1:0] part;

   always_comb begin
      state_in = state_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      a_neg_in = a_neg_ff;
      b_neg_in = b_neg_ff;
      ua2_in   = ua2_ff;
      ub2_in   = ub2_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      nx_in    = nx_ff;
      ny_in    = ny_ff;

      ge       = (rem_ff >= RW'(sq_ff));
      diff     = ge ? (rem_ff - RW'(sq_ff)) : rem_ff;
      trial    = root_ff + bit_ff;
      root_rnd = '0;
      mag      = '0;
      part     = '0;

      case (state_ff)
         U_IDLE: begin
            if (start) begin
               a_neg_in = a_in[AW-1];
               b_neg_in = b_in[AW-1];
               ua_in    = a_in[AW-1] ? AW'(-a_in) : AW'(a_in);
               ub_in    = b_in[AW-1] ? AW'(-b_in) : AW'(b_in);
               state_in = U_SQ;
            end
         end
         U_SQ: begin
            ua2_in   = ua_ff * ua_ff;
            ub2_in   = ub_ff * ub_ff;
            state_in = U_SUM;
         end
         U_SUM: begin
            sq_in = SQW'(ua2_ff) + SQW'(ub2_ff);
            if (ua_ff == '0 && ub_ff == '0) begin
               nx_in    = '0;
               ny_in    = '0;
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else begin
               rem_in   = RW'(ua2_ff);
               quo_in   = '0;
               cnt_in   = '0;
               phase_in = 1'b0;
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            // one quotient bit of num * 2^30 / sq per cycle
            rem_in = {diff[RW-2:0], 1'b0};
            quo_in = {quo_ff[DIV_STEPS-2:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS-1)) begin
               rad_in   = ROOT_W'(quo_in);
               root_in  = '0;
               bit_in   = ROOT_TOP;
               cnt_in   = '0;
               state_in = U_ROOT;
            end
         end
         U_ROOT: begin
            if (rad_ff >= trial) begin
               rad_in  = rad_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROOT_STEPS-1)) begin
               // largest m with (2m-1) <= root
               root_rnd = (root_in + 1'b1) >> 1;
               mag      = root_rnd[Q_BITS-1:0];
               part     = (phase_ff ? b_neg_ff : a_neg_ff) ? -$signed(mag) : $signed(mag);
               if (!phase_ff) begin
                  nx_in    = part;
                  rem_in   = RW'(ub2_ff);
                  quo_in   = '0;
                  cnt_in   = '0;
                  phase_in = 1'b1;
                  state_in = U_DIV;
               end else begin
                  ny_in    = part;
                  done_in  = 1'b1;
                  state_in = U_IDLE;
               end
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ua_ff    <= ua_in;
      ub_ff    <= ub_in;
      a_neg_ff <= a_neg_in;
      b_neg_ff <= b_neg_in;
      ua2_ff   <= ua2_in;
      ub2_ff   <= ub2_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
   end

   assign done = done_ff;
   assign nx   = nx_ff;
   assign ny   = ny_ff;
endmodule

[rtl/core/polygon_normals_bbox_setup.sv]
// Polygon setup: vertex and edge normal stores, bounding box, emit sequencer.
//
// Request channel (req_*): one vertex per request, req_closes_list on the
// last one. Vertices load at one per cycle while req_stall is low. The
// vertex that fills the store (MAX_VERTICES) closes the polygon as well.
// After the closing vertex req_stall stays high through the emit phase.
// Emit first walks the vertex store and writes one edge normal per vertex,
// then walks it again and sends one response per vertex, in order, with
// the vertex, its edge and corner normals and the bounding box;
// rsp_final_result marks the last one.
// Each normal goes through one shared normalizer: setup (square and sum),
// then per component a divide and a square root. The first response
// follows the closing vertex only after every edge normal and the first
// corner normal are computed. The response sits in an output register;
// rsp_stall holds it and the sequencer waits. Loading of the next
// polygon starts while the final response is still waiting.
// Reset (synchronous) empties the vertex count, restores the box and drops
// any pending response; store contents stay undefined until written.
module polygon_normals_bbox_setup import pnb_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic                         req_closes_list,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [IDX_BITS-1:0]          rsp_vertex_index,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic signed [Q_BITS-1:0]     rsp_edge_normal_x,
   output logic signed [Q_BITS-1:0]     rsp_edge_normal_y,
   output logic signed [Q_BITS-1:0]     rsp_corner_normal_x,
   output logic signed [Q_BITS-1:0]     rsp_corner_normal_y,
   output logic signed [COORD_BITS-1:0] rsp_box_left,
   output logic signed [COORD_BITS-1:0] rsp_box_bottom,
   output logic [COORD_BITS-1:0]        rsp_box_width,
   output logic [COORD_BITS-1:0]        rsp_box_height,
   output logic                         rsp_final_result
);
   localparam int C  = COORD_BITS;
   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = (C + 1 > NSUM_BITS) ? C + 1 : NSUM_BITS;
   localparam logic signed [C-1:0] POS_MAX = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] NEG_MAX = {1'b1, {(C-1){1'b0}}};

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_ERD   = 3'd1;
   localparam logic [2:0] S_EGO   = 3'd2;
   localparam logic [2:0] S_EWAIT = 3'd3;
   localparam logic [2:0] S_CRD   = 3'd4;
   localparam logic [2:0] S_CGO   = 3'd5;
   localparam logic [2:0] S_CWAIT = 3'd6;
   localparam logic [2:0] S_PUSH  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in, n_ff, n_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic signed [C-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [C-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0] o_idx_ff;
   logic signed [C-1:0] o_x_ff, o_y_ff, o_left_ff, o_bottom_ff;
   logic [C-1:0]        o_w_ff, o_h_ff;
   logic signed [Q_BITS-1:0] o_enx_ff, o_eny_ff, o_cnx_ff, o_cny_ff;
   logic                o_final_ff;

   logic                accept, last_in, last_idx, can_load, load_out;
   logic [IW-1:0]       idx_next, idx_prev, vaddr_b;
   logic [2*C-1:0]      v_a, v_b;
   logic [2*Q_BITS-1:0] e_a, e_b;
   logic                norm_start, norm_done;
   logic signed [AW-1:0] norm_a, norm_b;
   logic signed [Q_BITS-1:0] norm_nx, norm_ny;
   logic signed [AW-1:0] dx, dy;
   logic signed [C-1:0] va_x, va_y, vb_x, vb_y;
   logic signed [Q_BITS-1:0] ea_x, ea_y, eb_x, eb_y;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_LOAD);
   assign last_in   = req_closes_list || (cnt_ff == CW'(MAX_VERTICES - 1));
   assign last_idx  = (CW'(idx_ff) == n_ff - 1'b1);
   assign idx_next  = last_idx ? '0 : idx_ff + 1'b1;
   assign idx_prev  = (idx_ff == '0) ? IW'(n_ff - 1'b1) : idx_ff - 1'b1;
   assign vaddr_b   = idx_next;

   pnb_ram #(.W(2*C), .DEPTH(MAX_VERTICES), .IW(IW)) u_vstore (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (IW'(cnt_ff)),
      .wr_data   ({req_vertex_x, req_vertex_y}),
      .rd_addr_a (idx_ff),
      .rd_addr_b (vaddr_b),
      .rd_data_a (v_a),
      .rd_data_b (v_b)
   );

   pnb_ram #(.W(2*Q_BITS), .DEPTH(MAX_VERTICES), .IW(IW)) u_nstore (
      .clock     (clock),
      .wr_en     (state_ff == S_EWAIT && norm_done),
      .wr_addr   (idx_ff),
      .wr_data   ({norm_nx, norm_ny}),
      .rd_addr_a (idx_ff),
      .rd_addr_b (idx_prev),
      .rd_data_a (e_a),
      .rd_data_b (e_b)
   );

   assign va_x = v_a[2*C-1:C];
   assign va_y = v_a[C-1:0];
   assign vb_x = v_b[2*C-1:C];
   assign vb_y = v_b[C-1:0];
   assign ea_x = e_a[2*Q_BITS-1:Q_BITS];
   assign ea_y = e_a[Q_BITS-1:0];
   assign eb_x = e_b[2*Q_BITS-1:Q_BITS];
   assign eb_y = e_b[Q_BITS-1:0];
   assign dx   = AW'(vb_x) - AW'(va_x);
   assign dy   = AW'(vb_y) - AW'(va_y);

   // edge normal is (dy, -dx); corner normal is the sum of adjacent edge normals
   always_comb begin
      if (state_ff == S_CGO) begin
         norm_a = AW'(ea_x) + AW'(eb_x);
         norm_b = AW'(ea_y) + AW'(eb_y);
      end else begin
         norm_a = dy;
         norm_b = -dx;
      end
   end
   assign norm_start = (state_ff == S_EGO) || (state_ff == S_CGO);

   pnb_norm #(.AW(AW)) u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .a_in  (norm_a),
      .b_in  (norm_b),
      .done  (norm_done),
      .nx    (norm_nx),
      .ny    (norm_ny)
   );

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == S_PUSH) && can_load;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      min_x_in     = min_x_ff;
      min_y_in     = min_y_ff;
      max_x_in     = max_x_ff;
      max_y_in     = max_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               cnt_in = cnt_ff + 1'b1;
               if (req_vertex_x < min_x_ff) min_x_in = req_vertex_x;
               if (req_vertex_y < min_y_ff) min_y_in = req_vertex_y;
               if (req_vertex_x > max_x_ff) max_x_in = req_vertex_x;
               if (req_vertex_y > max_y_ff) max_y_in = req_vertex_y;
               if (last_in) begin
                  n_in     = cnt_ff + 1'b1;
                  idx_in   = '0;
                  state_in = S_ERD;
               end
            end
         end
         S_ERD:   state_in = S_EGO;
         S_EGO:   state_in = S_EWAIT;
         S_EWAIT: begin
            if (norm_done) begin
               idx_in   = idx_next;
               state_in = last_idx ? S_CRD : S_ERD;
            end
         end
         S_CRD:   state_in = S_CGO;
         S_CGO:   state_in = S_CWAIT;
         S_CWAIT: begin
            if (norm_done) state_in = S_PUSH;
         end
         S_PUSH: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               if (last_idx) begin
                  // polygon done: back to the empty state
                  cnt_in   = '0;
                  min_x_in = POS_MAX;
                  min_y_in = POS_MAX;
                  max_x_in = NEG_MAX;
                  max_y_in = NEG_MAX;
                  idx_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_CRD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         min_x_ff     <= POS_MAX;
         min_y_ff     <= POS_MAX;
         max_x_ff     <= NEG_MAX;
         max_y_ff     <= NEG_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      if (load_out) begin
         o_idx_ff    <= IDX_BITS'(idx_ff);
         o_x_ff      <= va_x;
         o_y_ff      <= va_y;
         o_enx_ff    <= ea_x;
         o_eny_ff    <= ea_y;
         o_cnx_ff    <= norm_nx;
         o_cny_ff    <= norm_ny;
         o_left_ff   <= min_x_ff;
         o_bottom_ff <= min_y_ff;
         o_w_ff      <= C'(max_x_ff - min_x_ff);
         o_h_ff      <= C'(max_y_ff - min_y_ff);
         o_final_ff  <= last_idx;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vertex_index    = o_idx_ff;
   assign rsp_out_x           = o_x_ff;
   assign rsp_out_y           = o_y_ff;
   assign rsp_edge_normal_x   = o_enx_ff;
   assign rsp_edge_normal_y   = o_eny_ff;
   assign rsp_corner_normal_x = o_cnx_ff;
   assign rsp_corner_normal_y = o_cny_ff;
   assign rsp_box_left        = o_left_ff;
   assign rsp_box_bottom      = o_bottom_ff;
   assign rsp_box_width       = o_w_ff;
   assign rsp_box_height      = o_h_ff;
   assign rsp_final_result    = o_final_ff;
endmodule

[rtl/core/pnb_checker.sv]
// Port-level checker for the polygon setup block, bound to the top level.
`include "assert_macros.svh"
module pnb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_closes_list,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_final_result
);
   logic close_acc;

   assign close_acc = req_valid && !req_stall && req_closes_list;

   `PNB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `PNB_ASSERT_NXT(a_close_busy, clock, reset, close_acc, req_stall)
   `PNB_ASSERT_IMP(a_load_final, clock, reset, rsp_valid && !req_stall, rsp_final_result)
   `PNB_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && !req_stall)
endmodule

bind polygon_normals_bbox_setup pnb_checker u_pnb_checker (.*);
